// ===== src/bresenham_line_stepper_defines.svh =====
// assertion macros shared by the line stepper rtl
`ifndef BRESENHAM_LINE_STEPPER_DEFINES_SVH
`define BRESENHAM_LINE_STEPPER_DEFINES_SVH

`ifndef ASSERT_OFF

// condition holds at every clock edge out of reset
`define BLS_ASSERT(label, expr) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error("assertion failed");

// consequent holds in the same cycle as the antecedent
`define BLS_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// consequent holds in the cycle after the antecedent
`define BLS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`else

`define BLS_ASSERT(label, expr)
`define BLS_ASSERT_IMPL(label, ante, cons)
`define BLS_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ===== src/bls_pkg.sv =====
// shared types and codes for the line stepper
package bls_pkg;

	// request kinds on the input channel
	typedef enum logic {
		REQ_LOAD = 1'b0,
		REQ_STEP = 1'b1
	} req_type_t;

endpackage

// ===== src/bls_if.sv =====
// valid/ready channel interfaces for line requests and pixels

// request channel: line load or pixel step
interface bls_req_if #(
	parameter int COORD_BITS = 12
);
	logic                         valid;
	logic                         ready;
	bls_pkg::req_type_t           req_type;
	logic signed [COORD_BITS-1:0] start_x;
	logic signed [COORD_BITS-1:0] start_y;
	logic signed [COORD_BITS-1:0] end_x;
	logic signed [COORD_BITS-1:0] end_y;

	modport source (
		output valid, req_type, start_x, start_y, end_x, end_y,
		input  ready
	);
	modport sink (
		input  valid, req_type, start_x, start_y, end_x, end_y,
		output ready
	);
endinterface

// pixel channel
interface bls_pix_if #(
	parameter int COORD_BITS = 12
);
	logic                         valid;
	logic                         ready;
	logic signed [COORD_BITS-1:0] pixel_x;
	logic signed [COORD_BITS-1:0] pixel_y;
	logic                         last_pixel;

	modport source (
		output valid, pixel_x, pixel_y, last_pixel,
		input  ready
	);
	modport sink (
		input  valid, pixel_x, pixel_y, last_pixel,
		output ready
	);
endinterface

// ===== src/bls_front.sv =====
// front end: accepts requests and turns loads into ready-to-use line setup
module bls_front #(
	parameter int  COORD_BITS = 12,
	parameter type cmd_t      = logic
) (
	bls_req_if.sink req,
	output logic    push_valid,
	input  logic    push_ready,
	output cmd_t    push_cmd
);

	logic signed [COORD_BITS-1:0] sx, sy, ex, ey;
	logic                         x_neg, y_neg;
	logic        [COORD_BITS:0]   dx_full, dy_full;
	logic        [COORD_BITS-1:0] adx, ady;

	// deltas, directions and starting error term
	always_comb begin
		sx = req.start_x;
		sy = req.start_y;
		ex = req.end_x;
		ey = req.end_y;
		x_neg = sx > ex;
		y_neg = sy > ey;
		dx_full = x_neg ? ({sx[COORD_BITS-1], sx} - {ex[COORD_BITS-1], ex})
		                : ({ex[COORD_BITS-1], ex} - {sx[COORD_BITS-1], sx});
		dy_full = y_neg ? ({sy[COORD_BITS-1], sy} - {ey[COORD_BITS-1], ey})
		                : ({ey[COORD_BITS-1], ey} - {sy[COORD_BITS-1], sy});
		adx = dx_full[COORD_BITS-1:0];
		ady = dy_full[COORD_BITS-1:0];
	end

	// command word for the queue
	always_comb begin
		push_cmd            = '0;
		push_cmd.is_load    = (req.req_type == bls_pkg::REQ_LOAD);
		push_cmd.start_x    = sx;
		push_cmd.start_y    = sy;
		push_cmd.end_x      = ex;
		push_cmd.end_y      = ey;
		push_cmd.abs_dx     = adx;
		push_cmd.abs_dy     = ady;
		push_cmd.step_x_neg = x_neg;
		push_cmd.step_y_neg = y_neg;
		push_cmd.error_term = {2'b00, adx} - {2'b00, ady};
	end

	// handshake passes straight to the queue
	assign push_valid = req.valid;
	assign req.ready  = push_ready;

endmodule

// ===== src/bls_fifo.sv =====
// small command queue between front and back end
`include "bresenham_line_stepper_defines.svh"

module bls_fifo #(
	parameter type         item_t = logic,
	parameter int unsigned DEPTH  = 2
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  wr_valid,
	output logic  wr_ready,
	input  item_t wr_data,
	output logic  rd_valid,
	input  logic  rd_ready,
	output item_t rd_data
);

	localparam int unsigned PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_BITS = $clog2(DEPTH + 1);

	item_t               mem_q [DEPTH];
	logic [PTR_BITS-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_BITS-1:0] count_q;
	logic                push, pop;

	assign wr_ready = (count_q != CNT_BITS'(DEPTH));
	assign rd_valid = (count_q != '0);
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_valid && rd_ready;
	assign rd_data  = mem_q[rd_ptr_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	`BLS_ASSERT(a_fifo_count_range, count_q <= CNT_BITS'(DEPTH))
	`BLS_ASSERT_NEXT(a_fifo_push_grows, push && !pop, count_q == $past(count_q) + 1'b1)

endmodule

// ===== src/bls_back.sv =====
// back end: holds the line state, steps it and registers each pixel
`include "bresenham_line_stepper_defines.svh"

module bls_back #(
	parameter int  COORD_BITS = 12,
	parameter type cmd_t      = logic
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cmd_valid,
	output logic      cmd_ready,
	input  cmd_t      cmd,
	bls_pix_if.source pix
);

	localparam int EW = COORD_BITS + 2;

	logic signed [COORD_BITS-1:0] cur_x_q, cur_y_q, tgt_x_q, tgt_y_q;
	logic        [COORD_BITS-1:0] adx_q, ady_q;
	logic                         xneg_q, yneg_q;
	logic signed [EW-1:0]         err_q;
	logic signed [COORD_BITS-1:0] pix_x_q, pix_y_q;
	logic                         last_q, out_valid_q;

	logic                         active, out_free, pop, emit;
	logic signed [EW:0]           e2, ady_ext, adx_ext;
	logic                         take_x, take_y;
	logic signed [COORD_BITS-1:0] nx, ny;
	logic signed [EW-1:0]         err_nx;

	// queue handshake: a step waits for room in the output register
	always_comb begin
		active    = (cur_x_q != tgt_x_q) || (cur_y_q != tgt_y_q);
		out_free  = !out_valid_q || pix.ready;
		cmd_ready = cmd.is_load || out_free;
		pop       = cmd_valid && cmd_ready;
		emit      = pop && !cmd.is_load && active;
	end

	// error rule and next point
	always_comb begin
		e2      = {err_q, 1'b0};
		ady_ext = {3'b000, ady_q};
		adx_ext = {3'b000, adx_q};
		take_x  = e2 > -ady_ext;
		take_y  = e2 < adx_ext;
		nx      = cur_x_q;
		ny      = cur_y_q;
		if (take_x) begin
			nx = xneg_q ? cur_x_q - 1'b1 : cur_x_q + 1'b1;
		end
		if (take_y) begin
			ny = yneg_q ? cur_y_q - 1'b1 : cur_y_q + 1'b1;
		end
		err_nx = err_q - (take_x ? {2'b00, ady_q} : '0) + (take_y ? {2'b00, adx_q} : '0);
	end

	// line state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_x_q <= '0;
			cur_y_q <= '0;
			tgt_x_q <= '0;
			tgt_y_q <= '0;
			adx_q   <= '0;
			ady_q   <= '0;
			xneg_q  <= 1'b0;
			yneg_q  <= 1'b0;
			err_q   <= '0;
		end else if (pop && cmd.is_load) begin
			cur_x_q <= cmd.start_x;
			cur_y_q <= cmd.start_y;
			tgt_x_q <= cmd.end_x;
			tgt_y_q <= cmd.end_y;
			adx_q   <= cmd.abs_dx;
			ady_q   <= cmd.abs_dy;
			xneg_q  <= cmd.step_x_neg;
			yneg_q  <= cmd.step_y_neg;
			err_q   <= cmd.error_term;
		end else if (emit) begin
			cur_x_q <= nx;
			cur_y_q <= ny;
			err_q   <= err_nx;
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (pix.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (emit) begin
			pix_x_q <= cur_x_q;
			pix_y_q <= cur_y_q;
			last_q  <= (nx == tgt_x_q) && (ny == tgt_y_q);
		end
	end

	assign pix.valid      = out_valid_q;
	assign pix.pixel_x    = pix_x_q;
	assign pix.pixel_y    = pix_y_q;
	assign pix.last_pixel = last_q;

	`BLS_ASSERT_NEXT(a_back_done_step_holds, pop && !cmd.is_load && !active, $stable(cur_x_q) && $stable(cur_y_q) && $stable(err_q))
	`BLS_ASSERT_NEXT(a_back_load_sets_line, pop && cmd.is_load, cur_x_q == $past(cmd.start_x) && tgt_y_q == $past(cmd.end_y))
	`BLS_ASSERT_IMPL(a_back_stall_blocks_step, cmd_valid && !cmd.is_load && out_valid_q && !pix.ready, !cmd_ready)

endmodule

// ===== src/bresenham_line_stepper.sv =====
// top level of the bresenham line stepper
//
//   channel  dir  payload                                  role
//   req      in   req_type, start_x, start_y, end_x, end_y  line load or pixel step
//   pix      out  pixel_x, pixel_y, last_pixel              one pixel per active step
//
// sustained rate is one transaction per cycle while pix is not stalled.
// a pixel reaches the output register after its step transaction passes the
// two-entry command queue, which registers each command between front and back end.
// reset clears all line state to zero, so steps before any load give no pixel.
// a stall on pix holds step commands in the queue; loads and steps stay in order.
module bresenham_line_stepper #(
	parameter int COORD_BITS = 12
) (
	input  logic      clk,
	input  logic      arst_n,
	bls_req_if.sink   req,
	bls_pix_if.source pix
);

	typedef struct packed {
		logic                         is_load;
		logic signed [COORD_BITS-1:0] start_x;
		logic signed [COORD_BITS-1:0] start_y;
		logic signed [COORD_BITS-1:0] end_x;
		logic signed [COORD_BITS-1:0] end_y;
		logic        [COORD_BITS-1:0] abs_dx;
		logic        [COORD_BITS-1:0] abs_dy;
		logic                         step_x_neg;
		logic                         step_y_neg;
		logic signed [COORD_BITS+1:0] error_term;
	} cmd_t;

	logic push_valid, push_ready, pop_valid, pop_ready;
	cmd_t push_cmd, pop_cmd;

	// request decode and line setup
	bls_front #(
		.COORD_BITS (COORD_BITS),
		.cmd_t      (cmd_t)
	) u_front (
		.req        (req),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_cmd   (push_cmd)
	);

	// command queue
	bls_fifo #(
		.item_t (cmd_t),
		.DEPTH  (2)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (push_valid),
		.wr_ready (push_ready),
		.wr_data  (push_cmd),
		.rd_valid (pop_valid),
		.rd_ready (pop_ready),
		.rd_data  (pop_cmd)
	);

	// line stepping and pixel output
	bls_back #(
		.COORD_BITS (COORD_BITS),
		.cmd_t      (cmd_t)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (pop_valid),
		.cmd_ready (pop_ready),
		.cmd       (pop_cmd),
		.pix       (pix)
	);

endmodule
